### rtl/core/rse_pkg.sv
// Package for the rotary speaker effect: widths, register indexes, sine table function.
// No dependencies; used by the interfaces, the top level, rse_lfo and rse_delay_lane.
package rse_pkg;

    localparam int DelayLength   = 2048;
    localparam int SampleBits    = 24;
    localparam int SineTableSize = 256;
    localparam int PhaseBits     = 24;
    localparam int CfgIdxBits    = 3;
    localparam int CfgDataBits   = 16;
    localparam int NumLanes      = 4;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_HORN_STEP   = 3'd0,
        REG_ROTOR_STEP  = 3'd1,
        REG_XOVER_COEF  = 3'd2,
        REG_HORN_EXC    = 3'd3,
        REG_ROTOR_EXC   = 3'd4,
        REG_WET_MIX     = 3'd5,
        REG_HORN_BAL    = 3'd6
    } t_reg_idx;

    // Control handed from the sequencer to each delay lane.
    typedef struct packed {
        logic wr_en;
        logic rd0_en;
        logic rd1_en;
        logic interp_en;
    } t_lane_ctrl;

    // Scales down by 2^30 with truncation toward zero, as integer division does.
    function automatic longint trunc_q30(input longint v);
        return (v < 0) ? -((-v) >>> 30) : (v >>> 30);
    endfunction

    // Sine of 2*pi*k/size scaled by 2^15, by fixed-point polynomial evaluation. Used
    // only at elaboration to fill the constant table; size is a power of two.
    function automatic logic signed [15:0] sine_value(input longint k, input longint size);
        longint t, u, u2, p, s, r;
        int     quad;
        t = k <<< (32 - $clog2(size));
        quad = int'((t >>> 30) & 3);
        u = t & 64'h3FFF_FFFF;
        if ((quad & 1) == 1) u = (64'sd1 <<< 30) - u;
        u2 = (u * u) >>> 30;
        p = 172228;
        p = -5026937 + trunc_q30(p * u2);
        p = 85569278 + trunc_q30(p * u2);
        p = -693598671 + trunc_q30(p * u2);
        p = 1686629713 + trunc_q30(p * u2);
        s = trunc_q30(u * p);
        if (s < 0) s = 0;
        r = (s + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (quad >= 2) r = -r;
        return 16'(r);
    endfunction

endpackage

### rtl/core/rse_stream_if.sv
// Valid/ready stream interface carrying a stereo sample pair.
// Depends on rse_pkg for the sample width.
interface rse_stream_if #(
    parameter int SAMPLE_BITS = rse_pkg::SampleBits
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;

    modport source (output valid, output left, output right, input ready);
    modport sink   (input valid, input left, input right, output ready);
endinterface

### rtl/core/rse_cfg_if.sv
// Register write channel: valid/ready with register index and data.
// Depends on rse_pkg for index and data widths.
interface rse_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rse_pkg::CfgIdxBits-1:0]      index;
    logic [rse_pkg::CfgDataBits-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/rotary_speaker_effect.sv
// Top level of the rotary speaker effect: crossover, two LFOs, four delay lanes, mixer.
// Depends on rse_pkg, rse_stream_if, rse_cfg_if, rse_lfo, rse_delay_lane.
//
//  channel   direction  payload               handshake
//  s_in      sink       left, right samples   valid/ready
//  s_out     source     left, right samples   valid/ready
//  s_cfg     sink       index, data           valid/ready
//
// An item passes from transfer in through the XOVER, LFO, RD0, RD1, INTP, AM, WGT,
// SUM, MIX, SAT and OUT states into the output register; the mix chain of registered
// multiplies and the two serial reads per delay memory set that sequence. After reset
// a clearing pass zeroes the four memories; no item is taken during it. A new item is
// taken only once the previous result has moved into the output register, so a
// stalled output blocks at most one item.
module rotary_speaker_effect
    import rse_pkg::*;
#(
    parameter int DELAY_LENGTH    = rse_pkg::DelayLength,
    parameter int SAMPLE_BITS     = rse_pkg::SampleBits,
    parameter int SINE_TABLE_SIZE = rse_pkg::SineTableSize
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rse_stream_if.sink    s_in,
    rse_stream_if.source  s_out,
    rse_cfg_if.sink       s_cfg
);
    localparam int AW = $clog2(DELAY_LENGTH);
    localparam int SB = SAMPLE_BITS;
    localparam int NS = 13;

    typedef enum logic [NS-1:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_XOVER = 13'b0000000000100,
        ST_LFO   = 13'b0000000001000,
        ST_RD0   = 13'b0000000010000,
        ST_RD1   = 13'b0000000100000,
        ST_INTP  = 13'b0000001000000,
        ST_AM    = 13'b0000010000000,
        ST_WGT   = 13'b0000100000000,
        ST_SUM   = 13'b0001000000000,
        ST_MIX   = 13'b0010000000000,
        ST_SAT   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [12:0] r_horn_step, r_rotor_step;
    logic [15:0] r_coef, r_horn_exc, r_rotor_exc, r_wet, r_bal;

    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horn_step  <= 13'd1171;
            r_rotor_step <= 13'd913;
            r_coef       <= 16'd6515;
            r_horn_exc   <= 16'd6636;
            r_rotor_exc  <= 16'd13271;
            r_wet        <= 16'd39322;
            r_bal        <= 16'd32768;
        end else if (s_cfg.valid) begin
            unique case (t_reg_idx'(s_cfg.index))
                REG_HORN_STEP:  r_horn_step  <= s_cfg.data[12:0];
                REG_ROTOR_STEP: r_rotor_step <= s_cfg.data[12:0];
                REG_XOVER_COEF: r_coef       <= s_cfg.data;
                REG_HORN_EXC:   r_horn_exc   <= s_cfg.data;
                REG_ROTOR_EXC:  r_rotor_exc  <= s_cfg.data;
                REG_WET_MIX:    r_wet        <= s_cfg.data;
                REG_HORN_BAL:   r_bal        <= s_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer and clearing pass.
    logic [AW:0]  r_clr_cnt;
    logic [AW-1:0] r_wr_idx;
    logic         r_out_valid;
    logic         c_in_xfer;

    assign s_in.ready = (r_state == ST_IDLE);
    assign c_in_xfer  = s_in.valid && s_in.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_cnt == (AW+1)'(DELAY_LENGTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (s_in.valid) n_state = ST_XOVER;
            ST_XOVER: n_state = ST_LFO;
            ST_LFO:   n_state = ST_RD0;
            ST_RD0:   n_state = ST_RD1;
            ST_RD1:   n_state = ST_INTP;
            ST_INTP:  n_state = ST_AM;
            ST_AM:    n_state = ST_WGT;
            ST_WGT:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_MIX;
            ST_MIX:   n_state = ST_SAT;
            ST_SAT:   n_state = ST_OUT;
            ST_OUT:   if (!r_out_valid || s_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_wr_idx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_state == ST_INTP) r_wr_idx <= r_wr_idx + 1'b1;
        end
    end

    // Crossover: low band kept scaled by 256.
    logic signed [SB-1:0] r_l, r_r;
    logic signed [SB:0]   c_sum;
    logic signed [SB-1:0] c_x;
    logic signed [SB+8:0] r_low;
    logic signed [SB+9:0] c_err;
    logic signed [SB+26:0] c_upd;
    logic signed [SB+8:0] c_low_n;
    logic signed [SB-1:0] r_lo, r_hi;
    logic signed [SB:0]   c_hi_w;
    logic signed [SB-1:0] c_sat_max, c_sat_min;

    assign c_sat_max = {1'b0, {(SB-1){1'b1}}};
    assign c_sat_min = {1'b1, {(SB-1){1'b0}}};
    assign c_sum   = (SB+1)'(r_l) + (SB+1)'(r_r);
    assign c_x     = SB'(c_sum >>> 1);
    assign c_err   = ((SB+10)'(c_x) <<< 8) - (SB+10)'(r_low);
    assign c_upd   = (SB+27)'($signed({1'b0, r_coef})) * (SB+27)'(c_err);
    assign c_low_n = r_low + (SB+9)'(c_upd >>> 16);
    assign c_hi_w  = (SB+1)'(c_x) - (SB+1)'(SB'(c_low_n >>> 8));

    always_ff @(posedge i_clk) begin
        if (c_in_xfer) begin
            r_l <= s_in.left;
            r_r <= s_in.right;
        end
        if (r_state == ST_XOVER) begin
            r_lo <= SB'(c_low_n >>> 8);
            if (c_hi_w > (SB+1)'(c_sat_max))      r_hi <= c_sat_max;
            else if (c_hi_w < (SB+1)'(c_sat_min)) r_hi <= c_sat_min;
            else                                  r_hi <= SB'(c_hi_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= '0;
        end else if (r_state == ST_XOVER) begin
            r_low <= c_low_n;
        end
    end

    // LFOs advance in the crossover step; sines are ready in ST_LFO.
    logic signed [15:0] c_sh, c_sr;
    rse_lfo #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_horn_lfo (
        .i_clk, .i_rst_n, .i_advance(r_state == ST_XOVER), .i_step(r_horn_step), .o_sine(c_sh)
    );
    rse_lfo #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_rotor_lfo (
        .i_clk, .i_rst_n, .i_advance(r_state == ST_XOVER), .i_step(r_rotor_step), .o_sine(c_sr)
    );

    // Four delay lanes: horn left, horn right, rotor left, rotor right.
    t_lane_ctrl c_ctrl;
    assign c_ctrl.wr_en     = (r_state == ST_LFO);
    assign c_ctrl.rd0_en    = (r_state == ST_RD0);
    assign c_ctrl.rd1_en    = (r_state == ST_RD1);
    assign c_ctrl.interp_en = (r_state == ST_INTP);

    logic signed [SB-1:0] c_tap [NumLanes];
    logic signed [SB-1:0] c_lane_in [NumLanes];
    logic [15:0]          c_lane_exc [NumLanes];
    logic signed [15:0]   c_lane_sin [NumLanes];

    assign c_lane_in[0] = r_hi;   assign c_lane_in[1] = r_hi;
    assign c_lane_in[2] = r_lo;   assign c_lane_in[3] = r_lo;
    assign c_lane_exc[0] = r_horn_exc;  assign c_lane_exc[1] = r_horn_exc;
    assign c_lane_exc[2] = r_rotor_exc; assign c_lane_exc[3] = r_rotor_exc;
    assign c_lane_sin[0] = c_sh;  assign c_lane_sin[1] = -c_sh;
    assign c_lane_sin[2] = c_sr;  assign c_lane_sin[3] = -c_sr;

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        rse_delay_lane #(.DELAY_LENGTH(DELAY_LENGTH), .SAMPLE_BITS(SB)) u_lane (
            .i_clk, .i_rst_n,
            .i_ctrl(c_ctrl), .i_wr_idx(r_wr_idx), .i_sample(c_lane_in[g]),
            .i_excursion(c_lane_exc[g]), .i_sine(c_lane_sin[g]),
            .i_clear_en(r_state == ST_CLEAR), .i_clear_idx(r_clr_cnt[AW-1:0]),
            .o_tap(c_tap[g])
        );
    end

    // Merge: tremolo, balance weights, wet/dry blend, saturation.
    logic signed [17:0] c_amh, c_amr;
    logic signed [SB+1:0] r_am [NumLanes];
    logic signed [SB+1:0] r_wt [NumLanes];
    logic signed [SB+2:0] r_wet_l, r_wet_r;
    logic signed [SB+19:0] r_mix_l, r_mix_r;
    logic signed [17:0]   c_hw, c_rw, c_g, c_dry;
    logic [33:0]          c_rwp, c_gp;

    assign c_amh = 18'sd45875 + 18'((34'(c_sh) * 34'sd19661) >>> 15);
    assign c_amr = 18'sd55706 + 18'((34'(c_sr) * 34'sd9830) >>> 15);
    assign c_hw  = 18'($signed({1'b0, r_bal}));
    assign c_rwp = 34'(r_bal) * 34'd26214;
    assign c_rw  = 18'sd65536 - 18'($signed({1'b0, c_rwp[31:16]}));
    assign c_gp  = 34'(r_wet) * 34'd85197;
    assign c_g   = 18'($signed({1'b0, c_gp[32:16]}));
    assign c_dry = 18'sd65536 - 18'($signed({1'b0, r_wet}));

    for (genvar g = 0; g < NumLanes; g++) begin : g_mrg
        always_ff @(posedge i_clk) begin
            if (r_state == ST_AM) begin
                r_am[g] <= (SB+2)'(((SB+20)'(c_tap[g]) * (SB+20)'(g < 2 ? c_amh : c_amr)) >>> 16);
            end
            if (r_state == ST_WGT) begin
                r_wt[g] <= (SB+2)'(((SB+20)'(r_am[g]) * (SB+20)'(g < 2 ? c_hw : c_rw)) >>> 16);
            end
        end
    end

    function automatic logic signed [SB-1:0] sat_fn(input logic signed [SB+19:0] v);
        logic signed [SB+3:0] s;
        s = (SB+4)'(v >>> 16);
        if (s > (SB+4)'(c_sat_max))      return c_sat_max;
        else if (s < (SB+4)'(c_sat_min)) return c_sat_min;
        else                             return SB'(s);
    endfunction

    logic signed [SB-1:0] r_ol, r_or;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_wet_l <= (SB+3)'(r_wt[0]) + (SB+3)'(r_wt[2]);
            r_wet_r <= (SB+3)'(r_wt[1]) + (SB+3)'(r_wt[3]);
        end
        if (r_state == ST_MIX) begin
            r_mix_l <= (SB+20)'(r_l) * (SB+20)'(c_dry) + (SB+20)'(r_wet_l) * (SB+20)'(c_g);
            r_mix_r <= (SB+20)'(r_r) * (SB+20)'(c_dry) + (SB+20)'(r_wet_r) * (SB+20)'(c_g);
        end
        if (r_state == ST_SAT) begin
            r_ol <= sat_fn(r_mix_l);
            r_or <= sat_fn(r_mix_r);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && (!r_out_valid || s_out.ready)) begin
            r_out_valid <= 1'b1;
        end else if (s_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_out_valid || s_out.ready)) begin
            s_out.left  <= r_ol;
            s_out.right <= r_or;
        end
    end

    assign s_out.valid = r_out_valid;
endmodule

### rtl/core/rse_lfo.sv
// LFO: 24-bit phase accumulator addressing a constant sine table, plus a
// registered sine output. Depends on rse_pkg.
module rse_lfo #(
    parameter int SINE_TABLE_SIZE = rse_pkg::SineTableSize
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [12:0]                    i_step,
    output logic signed [15:0]             o_sine
);
    import rse_pkg::*;

    localparam int TblBits = $clog2(SINE_TABLE_SIZE);

    logic signed [15:0] c_table [SINE_TABLE_SIZE];
    logic [PhaseBits-1:0] r_phase, n_phase;

    for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_tbl
        assign c_table[k] = sine_value(longint'(k), longint'(SINE_TABLE_SIZE));
    end

    assign n_phase = r_phase + PhaseBits'(i_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
    end

    // Table read uses the advanced phase, so the sine is ready with the new phase.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            o_sine <= c_table[n_phase[PhaseBits-1 -: TblBits]];
        end
    end
endmodule

### rtl/core/rse_delay_lane.sv
// One Doppler delay lane: memory, tap position from the LFO, two reads in turn on
// one port, then linear interpolation. Depends on rse_pkg.
module rse_delay_lane #(
    parameter int DELAY_LENGTH = rse_pkg::DelayLength,
    parameter int SAMPLE_BITS  = rse_pkg::SampleBits
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rse_pkg::t_lane_ctrl                i_ctrl,
    input  logic [$clog2(DELAY_LENGTH)-1:0]    i_wr_idx,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic [15:0]                        i_excursion,
    input  logic signed [15:0]                 i_sine,
    input  logic                               i_clear_en,
    input  logic [$clog2(DELAY_LENGTH)-1:0]    i_clear_idx,
    output logic signed [SAMPLE_BITS-1:0]      o_tap
);
    import rse_pkg::*;

    localparam int AW = $clog2(DELAY_LENGTH);

    logic signed [SAMPLE_BITS-1:0] r_mem [DELAY_LENGTH];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic signed [SAMPLE_BITS-1:0] r_b0;
    logic [AW-1:0]                 r_i0;
    logic [16:0]                   r_frac;
    logic [16:0]                   c_mod;
    logic [32:0]                   c_prod;
    logic [24:0]                   c_dly;
    logic [16:0]                   c_back;
    logic [AW-1:0]                 c_i0;
    logic signed [SAMPLE_BITS:0]   c_diff;
    logic signed [SAMPLE_BITS+17:0] c_scaled;

    // Delay in samples, kept in Q.16: 6 + E*(32768+s)/2^24; the sum is at most 17 bits wide.
    assign c_mod  = 17'(17'sd32768 + 17'(i_sine));
    assign c_prod = 33'(i_excursion) * 33'(c_mod);
    assign c_dly  = 25'(24'd393216) + 25'(c_prod[32:8]);
    assign c_back = (c_dly[15:0] != 16'd0) ? 17'(c_dly[24:16]) + 17'd1 : 17'(c_dly[24:16]);
    assign c_i0   = i_wr_idx - c_back[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_clear_en) begin
            r_mem[i_clear_idx] <= '0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_idx] <= i_sample;
        end
        if (i_ctrl.rd0_en) begin
            r_rd <= r_mem[c_i0];
        end else if (i_ctrl.rd1_en) begin
            r_rd <= r_mem[r_i0 + AW'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd0_en) begin
            r_i0   <= c_i0;
            r_frac <= (c_dly[15:0] != 16'd0) ? 17'd65536 - 17'(c_dly[15:0]) : 17'd0;
        end
        if (i_ctrl.rd1_en) begin
            r_b0 <= r_rd;
        end
    end

    assign c_diff   = (SAMPLE_BITS+1)'(r_rd) - (SAMPLE_BITS+1)'(r_b0);
    assign c_scaled = (SAMPLE_BITS+18)'($signed({1'b0, r_frac})) * (SAMPLE_BITS+18)'(c_diff);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.interp_en) begin
            o_tap <= SAMPLE_BITS'(r_b0 + SAMPLE_BITS'(c_scaled >>> 16));
        end
    end

    logic unused_rst;
    assign unused_rst = i_rst_n;
endmodule

### rtl/core/rse_checker.sv
// Port-level checks for the rotary speaker effect, attached by bind.
// Depends on rse_pkg, rse_stream_if and rse_cfg_if through the top level.
module rse_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_ready
);
    // An accepted item blocks the input until its result is produced.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after a transfer");

    // A result never appears without an item before it: no output right after reset.
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("output valid right after reset");

    // Stalled output holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output dropped while stalled");

    // Configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) cfg_ready)
        else $error("configuration channel not ready");
endmodule

bind rotary_speaker_effect rse_checker u_rse_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(s_out.valid), .out_ready(s_out.ready),
    .cfg_ready(s_cfg.ready)
);
